// File: rtl/core/svt_pkg.sv
// svt_pkg: shared types and codes for the sorted value table.
// Used by svt_cell and sorted_value_table; no dependencies.
package svt_pkg;

  localparam int VALUE_W   = 32;
  localparam int OP_W      = 2;
  localparam int STATUS_W  = 2;
  localparam int POS_W     = 4;
  localparam int COUNT_W   = 5;
  localparam int DEPTH_DEF = 16;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

  // What a cell shows its neighbors: its entry and how it compares to the operand.
  typedef struct packed {
    logic                       valid;
    logic signed [VALUE_W-1:0]  value;
    logic                       lt;
    logic                       eq;
  } link_t;

  // Broadcast to every cell in the chain.
  typedef struct packed {
    logic                       insert_en;
    logic                       remove_en;
    logic signed [VALUE_W-1:0]  value;
  } cmd_t;

endpackage

// File: rtl/core/sorted_value_table.sv
// sorted_value_table: top level; a chain of DEPTH svt_cell entries kept in
// ascending signed order, plus the result register. Uses svt_pkg and svt_cell.
//
// Usage:
//   Input stream (in_*): one transaction per operation; in_tdata carries the
//   op code (insert, remove, search) and a signed 32-bit operand.
//   Output stream (out_*): exactly one result per operation with status,
//   found flag, position and the entry count after the operation.
//   Every cell compares its entry with the operand in the same cycle and
//   loads from its left or right neighbor, so the whole table updates at once:
//   the result appears on out_tvalid in the cycle after acceptance, and a new
//   operation can be accepted every cycle while the receiver takes results.
//   The result register decouples the sides: in_tready stays high while the
//   result register is empty or being drained. When the receiver stalls,
//   the result holds and in_tready drops until it is taken.
//   Reset (rst_n low, synchronous) empties the table and the result register;
//   no clearing pass is needed, the block is ready once reset is released.
//   Position is cut to 4 bits (lossy for DEPTH above 16), count to 5 (above 31).
module sorted_value_table #(
  parameter int DEPTH = svt_pkg::DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [1:0] op, [33:2] value, [39:34] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [1:0] status, [2] found, [6:3] position,
                                  // [11:7] count, [15:12] zero
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int PW    = (IDX_W > svt_pkg::POS_W) ? IDX_W : svt_pkg::POS_W;
  localparam int CW    = (CNT_W > svt_pkg::COUNT_W) ? CNT_W : svt_pkg::COUNT_W;

  logic                               fire;
  logic [svt_pkg::OP_W-1:0]           in_op;
  logic signed [svt_pkg::VALUE_W-1:0] in_value;
  svt_pkg::cmd_t                      cmd;
  svt_pkg::link_t                     lnk [DEPTH+2];
  logic [DEPTH-1:0]                   hit_vec;
  logic [DEPTH-1:0]                   ins_vec;
  logic [DEPTH-1:0]                   valid_vec;
  logic                               found;
  logic                               full;
  logic                               empty;
  logic [PW-1:0]                      hit_pos;
  logic [PW-1:0]                      ins_pos;
  logic [CNT_W-1:0]                   count_r;
  logic [CNT_W-1:0]                   count_nxt;
  logic [CW-1:0]                      count_ext;
  logic [svt_pkg::STATUS_W-1:0]       status;
  logic                               res_found;
  logic [PW-1:0]                      res_pos;
  logic                               out_tvalid_r;
  logic                               out_tvalid_nxt;
  logic [15:0]                        out_tdata_r;
  logic [15:0]                        out_tdata_nxt;

  assign in_op    = in_tdata[1:0];
  assign in_value = $signed(in_tdata[33:2]);

  assign in_tready = !out_tvalid_r || out_tready;
  assign fire      = in_tvalid && in_tready;

  // chain ends: left of cell 0 acts as "less than everything", right end is empty
  assign lnk[0]       = '{valid: 1'b0, value: '0, lt: 1'b1, eq: 1'b0};
  assign lnk[DEPTH+1] = '{valid: 1'b0, value: '0, lt: 1'b0, eq: 1'b0};

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    svt_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .cmd    (cmd),
      .left   (lnk[g]),
      .right  (lnk[g+2]),
      .own    (lnk[g+1]),
      .hit    (hit_vec[g]),
      .ins_pt (ins_vec[g])
    );
    assign valid_vec[g] = lnk[g+1].valid;
  end

  assign full  = valid_vec[DEPTH-1];
  assign empty = !valid_vec[0];
  assign found = |hit_vec;

  assign cmd.value     = in_value;
  assign cmd.insert_en = fire && (in_op == svt_pkg::OP_INSERT) && !full;
  assign cmd.remove_en = fire && (in_op == svt_pkg::OP_REMOVE) && found;

  // flags are one-hot, so the index is an OR over the cells
  always_comb begin
    hit_pos = '0;
    ins_pos = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (hit_vec[i]) begin
        hit_pos = hit_pos | PW'(i);
      end
      if (ins_vec[i]) begin
        ins_pos = ins_pos | PW'(i);
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.insert_en) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.remove_en) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  assign count_ext = CW'(count_nxt);

  always_comb begin
    status    = svt_pkg::ST_OK;
    res_found = 1'b0;
    res_pos   = '0;
    unique case (in_op)
      svt_pkg::OP_INSERT: begin
        res_found = found;
        if (full) begin
          status = svt_pkg::ST_FULL;
        end else begin
          res_pos = ins_pos;
        end
      end
      svt_pkg::OP_REMOVE: begin
        if (empty) begin
          status = svt_pkg::ST_EMPTY;
        end else if (!found) begin
          status = svt_pkg::ST_NOT_FOUND;
        end else begin
          res_found = 1'b1;
          res_pos   = hit_pos;
        end
      end
      svt_pkg::OP_SEARCH: begin
        if (found) begin
          res_found = 1'b1;
          res_pos   = hit_pos;
        end else begin
          status = svt_pkg::ST_NOT_FOUND;
        end
      end
      default: begin
        status = svt_pkg::ST_OK;
      end
    endcase
  end

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    if (fire) begin
      out_tvalid_nxt = 1'b1;
      out_tdata_nxt  = {4'b0000, count_ext[svt_pkg::COUNT_W-1:0],
                        res_pos[svt_pkg::POS_W-1:0], res_found, status};
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      count_r      <= count_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_tdata_r <= out_tdata_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

`ifndef SYNTH
  a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_vec) == count_r)
    else $error("entry count disagrees with valid cells");

  a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    ((valid_vec + DEPTH'(1)) & valid_vec) == '0)
    else $error("valid cells are not a contiguous prefix");

  a_hit_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(hit_vec) && $onehot0(ins_vec))
    else $error("more than one first match or insert point");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.insert_en |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("insert did not grow the table");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_tvalid)
    else $error("accepted transaction produced no result");
`endif

endmodule

// File: rtl/core/svt_cell.sv
// svt_cell: one entry of the sorted chain; compares against the broadcast operand
// and shifts from its left (insert) or right (remove) neighbor. Uses svt_pkg.
module svt_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  svt_pkg::cmd_t  cmd,
  input  svt_pkg::link_t left,
  input  svt_pkg::link_t right,
  output svt_pkg::link_t own,
  output logic          hit,
  output logic          ins_pt
);

  logic                              valid_r;
  logic                              valid_nxt;
  logic signed [svt_pkg::VALUE_W-1:0] value_r;
  logic signed [svt_pkg::VALUE_W-1:0] value_nxt;
  logic                              own_le;
  logic                              left_le;

  assign own.valid = valid_r;
  assign own.value = value_r;
  assign own.lt    = valid_r && (value_r < cmd.value);
  assign own.eq    = valid_r && (value_r == cmd.value);

  assign own_le  = own.lt | own.eq;
  assign left_le = left.lt | left.eq;

  // equal entries are contiguous, so the first match is a rising edge of eq
  assign hit    = own.eq & ~left.eq;
  assign ins_pt = ~own_le & left_le;

  always_comb begin
    value_nxt = value_r;
    valid_nxt = valid_r;
    if (cmd.insert_en && !own_le) begin
      if (left_le) begin
        value_nxt = cmd.value;
        valid_nxt = 1'b1;
      end else begin
        value_nxt = left.value;
        valid_nxt = left.valid;
      end
    end else if (cmd.remove_en && !own.lt) begin
      value_nxt = right.value;
      valid_nxt = right.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

endmodule
